// ----- design/srb_pkg.sv -----
package srb_pkg;

  localparam int NumBanksDefault  = 4;
  localparam int BankDepthDefault = 16;
  localparam int MaxOut           = 64;
  localparam logic [6:0]  BatchSizeReset = 7'd16;
  localparam logic [31:0] MaxDelayReset  = 32'd1000;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_POLL  = 2'd1,
    CMD_DRAIN = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_BATCH = 1'b0,
    REG_DELAY = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_PLAN,
    ST_EMIT_SEL,
    ST_EMIT_OUT
  } state_e;

endpackage

// ----- design/srb_ram.sv -----
module srb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sharded_request_batcher.sv -----
// Sharded request batcher: bank FIFOs filled round-robin, released by size, age or drain.
// An enqueue without flush does one head scan over the banks; a poll adds a second head scan.
// Requests are taken one at a time; each popped item is read through the single RAM read
// port, after a plan pass over every bank and a head scan.
// Reset (rst_ni low, async): banks empty, round-robin at bank 0, batch size 16,
// max delay 1000. Slot RAM is not cleared; only written entries are ever read.
module sharded_request_batcher
  import srb_pkg::*;
#(
  parameter int NUM_BANKS  = NumBanksDefault,
  parameter int BANK_DEPTH = BankDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  // input requests
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // request_handle[31:0], time_stamp[79:32]
  input  logic [1:0]   s_axis_tuser,  // cmd[1:0]
  // results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // has_item[0], item_handle[32:1], item_time[80:33], end_of_batch[81],
  // was_empty_before[82], empty_after[83], rejected[84], count_after[91:85],
  // oldest_time[139:92], oldest_valid[140], zero fill[143:141]
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tlast   // last result of this request
);

  localparam int BW    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;  // bank index
  localparam int OW    = $clog2(NUM_BANKS + 1);                    // bank walk counter
  localparam int HW    = $clog2(BANK_DEPTH);                       // head pointer
  localparam int CW    = $clog2(BANK_DEPTH + 1);                   // per-bank count
  localparam int SLOTS = NUM_BANKS * BANK_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int TW    = $clog2(SLOTS + 1);                        // total count

  // ---------------------------------------------------------------- state
  state_e          state_q, state_d;
  logic [1:0]      cmd_q, cmd_d;
  logic [31:0]     hdl_q, hdl_d;
  logic [47:0]     ts_q, ts_d;
  logic [6:0]      bsz_q, bsz_d;        // batch size register
  logic [31:0]     dly_q, dly_d;
  logic [6:0]      bs_q, bs_d;          // clamped batch size for this request
  logic [HW-1:0]   head_q [NUM_BANKS];
  logic [HW-1:0]   head_d [NUM_BANKS];
  logic [CW-1:0]   cnt_q  [NUM_BANKS];
  logic [CW-1:0]   cnt_d  [NUM_BANKS];
  logic [HW-1:0]   head0_q [NUM_BANKS]; // head before popping, for the emit pass
  logic [HW-1:0]   head0_d [NUM_BANKS];
  logic [CW-1:0]   take_q [NUM_BANKS];  // items popped from each bank
  logic [CW-1:0]   take_d [NUM_BANKS];
  logic [TW-1:0]   total_q, total_d;
  logic [BW-1:0]   nb_q, nb_d;
  logic            was_empty_q, was_empty_d;
  logic            rej_q, rej_d;
  logic            batch_q, batch_d;    // 1: single batch, 0: drain cut per bank
  logic [BW-1:0]   start_q, start_d;
  logic [6:0]      rem_q, rem_d;
  logic [6:0]      npop_q, npop_d;
  logic [6:0]      sent_q, sent_d;
  logic [6:0]      bcnt_q, bcnt_d;
  logic [OW-1:0]   off_q, off_d;
  logic [CW-1:0]   j_q, j_d;
  logic            pre_q, pre_d;        // head scan before a poll decision
  logic            found_q, found_d;
  logic [BW-1:0]   obank_q, obank_d;
  logic [47:0]     otime_q, otime_d;
  logic            eob_q, eob_d;
  logic            last_q, last_d;

  // RAM
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [79:0]     ram_wdata, ram_rdata;
  logic [AW-1:0]   rd_addr;             // read address picked by the sequencer

  srb_ram #(
    .Width (80),
    .Depth (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic [HW-1:0] wrap_head(logic [HW-1:0] h, logic [CW-1:0] x);
    logic [HW+1:0] s;
    s = (HW+2)'(h) + (HW+2)'(x);
    if (s >= (HW+2)'(BANK_DEPTH)) s = s - (HW+2)'(BANK_DEPTH);
    return HW'(s);
  endfunction

  function automatic logic [BW-1:0] bank_of(logic [BW-1:0] st, logic [OW-1:0] o);
    logic [BW+1:0] s;
    s = (BW+2)'(st) + (BW+2)'(o);
    if (s >= (BW+2)'(NUM_BANKS)) s = s - (BW+2)'(NUM_BANKS);
    return BW'(s);
  endfunction

  function automatic logic [AW-1:0] slot_addr(logic [BW-1:0] b, logic [HW-1:0] h);
    return AW'(AW'(b) * AW'(BANK_DEPTH) + AW'(h));
  endfunction

  // ---------------------------------------------------------------- sequencer
  logic [BW-1:0] cur_bank;
  logic [BW-1:0] off_bank;
  logic [CW-1:0] take_v;
  logic [48:0]   due_time;

  assign cur_bank = bank_of(start_q, off_q);
  assign off_bank = off_q[BW-1:0];
  assign due_time = {1'b0, otime_q} + 49'(dly_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    hdl_d       = hdl_q;
    ts_d        = ts_q;
    bsz_d       = bsz_q;
    dly_d       = dly_q;
    bs_d        = bs_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    head0_d     = head0_q;
    take_d      = take_q;
    total_d     = total_q;
    nb_d        = nb_q;
    was_empty_d = was_empty_q;
    rej_d       = rej_q;
    batch_d     = batch_q;
    start_d     = start_q;
    rem_d       = rem_q;
    npop_d      = npop_q;
    sent_d      = sent_q;
    bcnt_d      = bcnt_q;
    off_d       = off_q;
    j_d         = j_q;
    pre_d       = pre_q;
    found_d     = found_q;
    obank_d     = obank_q;
    otime_d     = otime_q;
    eob_d       = eob_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = {ts_q, hdl_q};
    take_v      = '0;

    if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_BATCH: bsz_d = cfg_data_i[6:0];
        REG_DELAY: dly_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = s_axis_tuser;
          hdl_d   = s_axis_tdata[31:0];
          ts_d    = s_axis_tdata[79:32];
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        // clamp batch size into 1..64
        if (bsz_q == 7'd0) bs_d = 7'd1;
        else if (bsz_q > 7'(MaxOut)) bs_d = 7'(MaxOut);
        else bs_d = bsz_q;
        npop_d      = '0;
        sent_d      = '0;
        off_d       = '0;
        found_d     = 1'b0;
        rej_d       = 1'b0;
        was_empty_d = 1'b0;
        pre_d       = 1'b0;
        start_d     = '0;
        batch_d     = 1'b1;
        state_d     = ST_SCAN_RD;
        case (cmd_e'(cmd_q))
          CMD_ENQ: begin
            if (hdl_q != 32'd0) begin
              nb_d = (32'(nb_q) + 32'd1 >= 32'(NUM_BANKS)) ? '0 : BW'(nb_q + 1'b1);
              if (cnt_q[nb_q] >= CW'(BANK_DEPTH)) begin
                rej_d = 1'b1;
              end else begin
                ram_we        = 1'b1;
                ram_waddr     = slot_addr(nb_q, wrap_head(head_q[nb_q], cnt_q[nb_q]));
                was_empty_d   = (total_q == '0);
                cnt_d[nb_q]   = cnt_q[nb_q] + 1'b1;
                total_d       = total_q + 1'b1;
                // size flush
                if (16'(total_q) + 16'd1 >= 16'(bs_d)) begin
                  rem_d   = bs_d;
                  state_d = ST_PLAN;
                end
              end
            end
          end
          CMD_POLL: begin
            pre_d = 1'b1;
          end
          CMD_DRAIN: begin
            batch_d = 1'b0;
            rem_d   = 7'(MaxOut);
            state_d = ST_PLAN;
          end
          default: ;
        endcase
      end

      // walk banks, one head read for each non-empty bank
      ST_SCAN_RD: begin
        if (off_q == OW'(NUM_BANKS)) begin
          off_d = '0;
          if (pre_q) begin
            pre_d = 1'b0;
            if (found_q && {1'b0, ts_q} >= due_time) begin
              // age flush starting at the oldest head
              rem_d   = (16'(total_q) < 16'(bs_q)) ? 7'(total_q) : bs_q;
              start_d = obank_q;
              state_d = ST_PLAN;
            end else begin
              found_d = 1'b0;
            end
          end else begin
            j_d     = '0;
            bcnt_d  = '0;
            state_d = ST_EMIT_SEL;
          end
        end else if (cnt_q[off_bank] == '0) begin
          off_d = off_q + 1'b1;
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        if (!found_q || ram_rdata[79:32] < otime_q) begin
          found_d = 1'b1;
          otime_d = ram_rdata[79:32];
          obank_d = off_bank;
        end
        off_d   = off_q + 1'b1;
        state_d = ST_SCAN_RD;
      end

      // work out pops per bank on counts only
      ST_PLAN: begin
        if (off_q == OW'(NUM_BANKS)) begin
          off_d   = '0;
          found_d = 1'b0;
          state_d = ST_SCAN_RD;
        end else begin
          take_v = (7'(cnt_q[cur_bank]) < rem_q) ? cnt_q[cur_bank] : CW'(rem_q);
          take_d[cur_bank]  = take_v;
          head0_d[cur_bank] = head_q[cur_bank];
          head_d[cur_bank]  = wrap_head(head_q[cur_bank], take_v);
          cnt_d[cur_bank]   = cnt_q[cur_bank] - take_v;
          total_d = total_q - TW'(take_v);
          rem_d   = rem_q - 7'(take_v);
          npop_d  = npop_q + 7'(take_v);
          off_d   = off_q + 1'b1;
        end
      end

      ST_EMIT_SEL: begin
        if (npop_q == '0) begin
          last_d  = 1'b1;
          eob_d   = 1'b0;
          state_d = ST_EMIT_OUT;
        end else if (j_q >= take_q[cur_bank]) begin
          off_d  = off_q + 1'b1;
          j_d    = '0;
          bcnt_d = '0;
        end else begin
          last_d  = (sent_q + 7'd1 == npop_q);
          eob_d   = batch_q ? (sent_q + 7'd1 == npop_q)
                            : (bcnt_q + 7'd1 == bs_q || j_q + 1'b1 == take_q[cur_bank]);
          bcnt_d  = (bcnt_q + 7'd1 == bs_q) ? '0 : bcnt_q + 7'd1;
          sent_d  = sent_q + 7'd1;
          j_d     = j_q + 1'b1;
          state_d = ST_EMIT_OUT;
        end
      end

      ST_EMIT_OUT: begin
        if (m_axis_tready) begin
          state_d = last_q ? ST_IDLE : ST_EMIT_SEL;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  assign rd_addr = (state_q == ST_EMIT_SEL)
                   ? slot_addr(cur_bank, wrap_head(head0_q[cur_bank], j_q))
                   : slot_addr(off_bank, head_q[off_bank]);

  logic has_item;
  assign has_item = (npop_q != '0);

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = rd_addr;
    case (state_q)
      ST_IDLE:     s_axis_tready = 1'b1;
      ST_SCAN_RD:  ram_re = (off_q != OW'(NUM_BANKS)) && (cnt_q[off_bank] != '0);
      ST_EMIT_SEL: ram_re = has_item && (j_q < take_q[cur_bank]);
      ST_EMIT_OUT: m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tdata = {
    3'b000,
    found_q,
    found_q ? otime_q : 48'd0,
    7'(total_q),
    rej_q,
    (total_q == '0),
    was_empty_q,
    eob_q,
    has_item ? ram_rdata[79:32] : 48'd0,
    has_item ? ram_rdata[31:0] : 32'd0,
    has_item
  };
  assign m_axis_tlast = last_q;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bsz_q       <= BatchSizeReset;
      dly_q       <= MaxDelayReset;
      total_q     <= '0;
      nb_q        <= '0;
      npop_q      <= '0;
      sent_q      <= '0;
      off_q       <= '0;
      pre_q       <= 1'b0;
      found_q     <= 1'b0;
      last_q      <= 1'b0;
      for (int i = 0; i < NUM_BANKS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      bsz_q       <= bsz_d;
      dly_q       <= dly_d;
      total_q     <= total_d;
      nb_q        <= nb_d;
      npop_q      <= npop_d;
      sent_q      <= sent_d;
      off_q       <= off_d;
      pre_q       <= pre_d;
      found_q     <= found_d;
      last_q      <= last_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    hdl_q       <= hdl_d;
    ts_q        <= ts_d;
    bs_q        <= bs_d;
    head0_q     <= head0_d;
    take_q      <= take_d;
    was_empty_q <= was_empty_d;
    rej_q       <= rej_d;
    batch_q     <= batch_d;
    start_q     <= start_d;
    rem_q       <= rem_d;
    bcnt_q      <= bcnt_d;
    j_q         <= j_d;
    obank_q     <= obank_d;
    otime_q     <= otime_d;
    eob_q       <= eob_d;
  end

  // ---------------------------------------------------------------- checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tlast)
    else $error("status-only result not marked last");

  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after final result");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= 32'(SLOTS))
    else $error("queued total exceeds capacity");

endmodule
